// ----- src/thsh_pkg.sv -----
// Shared types, constants and the hash-table generator of the string hash block.
// Used by thsh_front, thsh_queue, thsh_back and table_seeded_string_hash.
// No dependencies.
package thsh_pkg;

  localparam int MaxTypes   = 5;
  localparam int SliceWords = 256;
  localparam int TableWords = MaxTypes * SliceWords;
  localparam int TableIdxW  = $clog2(TableWords);

  localparam logic [31:0] GenSeed     = 32'h0010_0001;
  localparam logic [31:0] GenMul      = 32'd125;
  localparam logic [31:0] GenMod      = 32'h002A_AAAB;
  localparam logic [31:0] SeedOneInit = 32'h7FED_7FED;
  localparam logic [31:0] SeedTwoInit = 32'hEEEE_EEEE;

  localparam logic [7:0] ChrEnd    = 8'h00;
  localparam logic [7:0] ChrLowA   = 8'h61;
  localparam logic [7:0] ChrLowZ   = 8'h7A;
  localparam logic [7:0] CaseDelta = 8'h20;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef logic [31:0] thsh_table_t [TableWords];

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic        last;
    logic [7:0]  chr;
    logic [31:0] word;
  } thsh_item_t;

  function automatic logic [31:0] gen_next(logic [31:0] s);
    logic [31:0] t;
    t = s * GenMul + 32'd3;
    return t % GenMod;
  endfunction

  // Evaluated once at elaboration; slices past n_types stay zero
  function automatic thsh_table_t build_table(int n_types);
    thsh_table_t tbl;
    logic [31:0] s;
    logic [15:0] hi;
    for (int k = 0; k < TableWords; k++) begin
      tbl[k] = '0;
    end
    s = GenSeed;
    for (int j = 0; j < SliceWords; j++) begin
      for (int t = 0; t < MaxTypes; t++) begin
        if (t < n_types) begin
          s = gen_next(s);
          hi = s[15:0];
          s = gen_next(s);
          tbl[t * SliceWords + j] = {hi, s[15:0]};
        end
      end
    end
    return tbl;
  endfunction

endpackage

// ----- src/thsh_front.sv -----
// Front stage: accepts a byte, uppercases it, saturates the hash type and
// reads the table word into a register. Depends on thsh_pkg.
module thsh_front #(
  parameter int HASH_TYPES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_name_byte,
  input  logic [2:0]          in_hash_type,
  output logic                push_valid,
  input  logic                push_ready,
  output thsh_pkg::thsh_item_t push_item
);

  localparam thsh_pkg::thsh_table_t HashTable = thsh_pkg::build_table(HASH_TYPES);
  localparam logic [2:0] TypeMax = 3'(HASH_TYPES - 1);

  logic                 f_valid_r;
  thsh_pkg::thsh_item_t f_item_r;
  logic [7:0]           chr_up;
  logic [2:0]           type_sat;
  logic [thsh_pkg::TableIdxW-1:0] tbl_idx;

  assign in_ready   = !f_valid_r || push_ready;
  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

  always_comb begin
    chr_up = in_name_byte;
    if (in_name_byte >= thsh_pkg::ChrLowA && in_name_byte <= thsh_pkg::ChrLowZ) begin
      chr_up = in_name_byte - thsh_pkg::CaseDelta;
    end
    type_sat = (in_hash_type > TypeMax) ? TypeMax : in_hash_type;
    tbl_idx  = thsh_pkg::TableIdxW'({type_sat, chr_up});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item_r.last <= (in_name_byte == thsh_pkg::ChrEnd);
      f_item_r.chr  <= chr_up;
      f_item_r.word <= HashTable[tbl_idx];
    end
  end

endmodule

// ----- src/thsh_queue.sv -----
// Short queue of classified bytes between the front and back stages.
// Depends on thsh_pkg.
module thsh_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  thsh_pkg::thsh_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output thsh_pkg::thsh_item_t pop_item
);

  thsh_pkg::thsh_item_t       mem_r [thsh_pkg::QDepth];
  logic [thsh_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [thsh_pkg::QCntW-1:0] count_r;
  logic                       do_push, do_pop;

  assign push_ready = (count_r != thsh_pkg::QCntW'(thsh_pkg::QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == thsh_pkg::QPtrW'(thsh_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == thsh_pkg::QPtrW'(thsh_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/thsh_back.sv -----
// Back stage: folds each byte into the two seeds and registers the hash when
// a string ends. Depends on thsh_pkg.
module thsh_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  thsh_pkg::thsh_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_hash_value
);

  logic [31:0] seed_one_r, seed_two_r;
  logic [31:0] seed_one_nxt, seed_two_nxt;
  logic        out_valid_r;
  logic [31:0] out_hash_r;
  logic        do_pop;

  // A terminator needs the output register free; plain bytes never wait
  assign pop_ready      = !pop_item.last || !out_valid_r || out_ready;
  assign do_pop         = pop_valid && pop_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    seed_one_nxt = pop_item.word ^ (seed_one_r + seed_two_r);
    seed_two_nxt = {24'd0, pop_item.chr} + seed_one_nxt + seed_two_r
                   + {seed_two_r[26:0], 5'd0} + 32'd3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_one_r  <= thsh_pkg::SeedOneInit;
      seed_two_r  <= thsh_pkg::SeedTwoInit;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_pop) begin
        if (pop_item.last) begin
          out_valid_r <= 1'b1;
          seed_one_r  <= thsh_pkg::SeedOneInit;
          seed_two_r  <= thsh_pkg::SeedTwoInit;
        end else begin
          seed_one_r <= seed_one_nxt;
          seed_two_r <= seed_two_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      out_hash_r <= seed_one_r;
    end
  end

endmodule

// ----- src/table_seeded_string_hash.sv -----
// Streaming table-seeded string hash, one name byte per input beat.
// Input channel (in_valid/in_ready): in_name_byte and in_hash_type. Bytes
// a..z are uppercased; in_hash_type above HASH_TYPES-1 saturates. A zero
// byte terminates the string and its in_hash_type is ignored.
// Output channel (out_valid/out_ready): one beat of out_hash_value per
// terminated string, carrying the final seed one; an empty string yields
// 0x7FED7FED.
// Throughput: one byte per cycle unless a terminator waits on a stalled
// receiver. The back-stage seed update is a combinational add/xor loop,
// and the table word is read in the front stage. A terminator passes the
// front register, the queue and the output register before out_valid.
// Reset (rst_n low, synchronous) empties the pipeline and loads both seeds
// with their initial values. The table is a constant built at elaboration.
// When the receiver stalls, the hash holds in the output register; plain
// bytes keep flowing, and input backpressure starts only once the next
// terminator reaches the back stage and the queue and front register fill.
module table_seeded_string_hash #(
  parameter int HASH_TYPES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic [2:0]  in_hash_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  thsh_pkg::thsh_item_t push_item, pop_item;

  thsh_front #(
    .HASH_TYPES(HASH_TYPES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_name_byte (in_name_byte),
    .in_hash_type (in_hash_type),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  thsh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  thsh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule
